@@ rtl/stprs_pkg.sv @@
package stprs_pkg;

  localparam int POS_W = 10;
  localparam int VAL_W = 32;
  localparam int SUM_W = 64;

  localparam logic KIND_SET   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic [POS_W-1:0]        position;
    logic [POS_W-1:0]        right_end;
    logic signed [VAL_W-1:0] value;
  } stprs_in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] range_sum;
    logic                    bad_range;
  } stprs_out_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SET_RD,
    S_SET_WR,
    S_Q_LO,
    S_Q_LO_ADD,
    S_Q_HI_ADD,
    S_OUT
  } stprs_state_t;

endpackage

@@ rtl/segment_tree_point_set_range_sum_unit.sv @@
// Sum segment tree over LEAVES leaves, node sums held in one heap-ordered RAM.
// Input channel (in_valid/in_stall/in_word): a set word writes one leaf and
// rewrites its ancestors; a query word asks for the sum over an inclusive
// leaf range. Only queries produce an output word (out_valid/out_stall/
// out_word), with bad_range set and a zero sum when left end > right end.
// One 64-bit adder and the single RAM read port are shared by both walks.
// Set: an accept state writes the leaf, then per tree level a sibling read
//   (S_SET_RD) and an add/write of the parent (S_SET_WR). No output word.
// Query: per level a lo read, a hi read overlapped with the lo add, and a
//   hi add, over at most log2(LEAVES)+1 levels, plus accept, final compare
//   (S_Q_LO) and result (S_OUT) states.
// in_stall is high whenever a word is in progress. Results land in an
// output register, so a new word is taken while a result waits; a query
// that finishes while that register is still stalled holds until it frees.
// After reset the RAM is swept to zero, one node per cycle, across all
// 2*LEAVES-1 nodes (2047 for 1024 leaves) with in_stall high.
module segment_tree_point_set_range_sum_unit import stprs_pkg::*; #(
  parameter int LEAVES = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  stprs_in_t  in_word,
  output logic       out_valid,
  input  logic       out_stall,
  output stprs_out_t out_word
);

  localparam int NODES = 2 * LEAVES - 1;
  localparam int NW    = $clog2(2 * LEAVES);
  localparam int CW    = (NW > POS_W) ? NW : POS_W;

  stprs_state_t state_r, state_nxt;
  logic [NW-1:0]    clr_r, clr_nxt;
  logic [NW-1:0]    c_r, c_nxt;
  logic [NW-1:0]    lo_r, lo_nxt;
  logic [NW-1:0]    hi_r, hi_nxt;
  logic [SUM_W-1:0] acc_r, acc_nxt;
  logic             bad_r, bad_nxt;
  logic             out_valid_r, out_valid_nxt;
  stprs_out_t       out_word_r;
  logic             out_ld;

  logic             ram_we, ram_re;
  logic [NW-1:0]    ram_waddr, ram_raddr;
  logic [SUM_W-1:0] ram_wdata, ram_rdata;

  logic [CW-1:0]    pos_c, rend_c, rend_cl;
  logic [NW-1:0]    leaf_idx, hi_init;
  logic [NW-1:0]    sib, parent, hi_m1, lo_walk, hi_walk;
  logic [SUM_W-1:0] val_ext, sum;

  stprs_node_ram #(
    .DEPTH (NODES),
    .AW    (NW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pos_c    = CW'(in_word.position);
  assign rend_c   = CW'(in_word.right_end);
  assign rend_cl  = (rend_c >= CW'(LEAVES - 1)) ? CW'(LEAVES - 1) : rend_c;
  assign leaf_idx = NW'(pos_c + CW'(LEAVES - 1));
  assign hi_init  = NW'(rend_cl + CW'(LEAVES));
  assign val_ext  = {{(SUM_W - VAL_W){in_word.value[VAL_W-1]}}, in_word.value};

  assign sib     = c_r[0] ? (c_r + NW'(1)) : (c_r - NW'(1));
  assign parent  = (c_r - NW'(1)) >> 1;
  assign hi_m1   = hi_r - NW'(1);
  assign lo_walk = lo_r >> 1;
  assign hi_walk = hi_m1 >> 1;

  // the one shared adder
  assign sum = acc_r + ram_rdata;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    c_nxt     = c_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    acc_nxt   = acc_r;
    bad_nxt   = bad_r;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    out_ld    = 1'b0;
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + NW'(1);
        if (clr_r == NW'(NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_word.kind == KIND_SET) begin
            // sets beyond the last leaf are dropped
            if (pos_c < CW'(LEAVES)) begin
              ram_we    = 1'b1;
              ram_waddr = leaf_idx;
              ram_wdata = val_ext;
              acc_nxt   = val_ext;
              c_nxt     = leaf_idx;
              state_nxt = S_SET_RD;
            end
          end else begin
            acc_nxt = '0;
            bad_nxt = 1'b0;
            if (pos_c > rend_c) begin
              bad_nxt   = 1'b1;
              state_nxt = S_OUT;
            end else if (pos_c > rend_cl) begin
              state_nxt = S_OUT;
            end else begin
              lo_nxt    = leaf_idx;
              hi_nxt    = hi_init;
              state_nxt = S_Q_LO;
            end
          end
        end
      end
      S_SET_RD: begin
        ram_re    = 1'b1;
        ram_raddr = sib;
        state_nxt = S_SET_WR;
      end
      S_SET_WR: begin
        ram_we    = 1'b1;
        ram_waddr = parent;
        ram_wdata = sum;
        acc_nxt   = sum;
        c_nxt     = parent;
        state_nxt = (parent == '0) ? S_IDLE : S_SET_RD;
      end
      S_Q_LO: begin
        if (lo_r >= hi_r) begin
          state_nxt = S_OUT;
        end else if (!lo_r[0]) begin
          ram_re    = 1'b1;
          ram_raddr = lo_r;
          state_nxt = S_Q_LO_ADD;
        end else if (!hi_r[0]) begin
          ram_re    = 1'b1;
          ram_raddr = hi_m1;
          state_nxt = S_Q_HI_ADD;
        end else begin
          lo_nxt = lo_walk;
          hi_nxt = hi_walk;
        end
      end
      S_Q_LO_ADD: begin
        acc_nxt = sum;
        // hi-side read overlaps the lo-side add
        if (!hi_r[0]) begin
          ram_re    = 1'b1;
          ram_raddr = hi_m1;
          state_nxt = S_Q_HI_ADD;
        end else begin
          lo_nxt    = lo_walk;
          hi_nxt    = hi_walk;
          state_nxt = S_Q_LO;
        end
      end
      S_Q_HI_ADD: begin
        acc_nxt   = sum;
        lo_nxt    = lo_walk;
        hi_nxt    = hi_walk;
        state_nxt = S_Q_LO;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_ld    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r   <= c_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    acc_r <= acc_nxt;
    bad_r <= bad_nxt;
    if (out_ld) begin
      out_word_r.range_sum <= $signed(acc_r);
      out_word_r.bad_range <= bad_r;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_bad_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.bad_range |-> out_word_r.range_sum == '0)
    else $error("bad_range result with nonzero sum");

  a_load_src : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result register loaded outside result state");

  a_clear_done : assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r) == S_CLEAR && state_r != S_CLEAR |-> $past(clr_r) == NW'(NODES - 1))
    else $error("clear sweep left early");

endmodule

@@ rtl/stprs_node_ram.sv @@
module stprs_node_ram import stprs_pkg::*; #(
  parameter int DEPTH = 2047,
  parameter int AW    = 11
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [SUM_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [SUM_W-1:0] rdata
);

  logic [SUM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stprs_pkg::*;

  localparam int LEAVES = 1024;
  localparam int NODES  = 2 * LEAVES - 1;
  localparam int unsigned TOP = LEAVES - 1;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  stprs_in_t  in_word;
  logic       out_valid;
  logic       out_stall;
  stprs_out_t out_word;

  // local copy of the tree, heap order: children of k are 2k+1 and 2k+2
  logic [SUM_W-1:0] node_sum [NODES];
  stprs_out_t       sums_due [$];
  stprs_out_t       due;
  int unsigned      mismatches = 0;

  bit          src_paced = 1'b1;
  bit          sink_paced = 1'b1;
  int unsigned sink_hold_extra = 0;

  segment_tree_point_set_range_sum_unit #(.LEAVES(LEAVES)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #1 clk = ~clk;

  function automatic int unsigned pause_for(bit paced);
    return paced ? $urandom_range(0, 19) : 0;
  endfunction

  function automatic logic [SUM_W-1:0] node_at(int unsigned k);
    return (k < NODES) ? node_sum[k] : '0;
  endfunction

  function automatic void store_leaf(int unsigned leaf, logic [VAL_W-1:0] v);
    int unsigned k;
    if (leaf >= LEAVES) return;
    k = leaf + LEAVES - 1;
    node_sum[k] = {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
    while (k > 0) begin
      k = (k - 1) / 2;
      node_sum[k] = node_at(2 * k + 1) + node_at(2 * k + 2);
    end
  endfunction

  // bottom-up walk, hi is exclusive
  function automatic logic [SUM_W-1:0] walk_sum(int unsigned lft, int unsigned rgt);
    logic [SUM_W-1:0] acc;
    int unsigned lo, hi;
    acc = '0;
    lo = lft + LEAVES - 1;
    hi = rgt + LEAVES;
    while (lo < hi) begin
      if ((lo & 1) == 0) acc += node_at(lo);
      if ((hi & 1) == 0) acc += node_at(hi - 1);
      lo = lo / 2;
      hi = (hi - 1) / 2;
    end
    return acc;
  endfunction

  function automatic stprs_out_t predict_query(int unsigned lft, int unsigned rgt);
    stprs_out_t r;
    r.range_sum = '0;
    r.bad_range = 1'b0;
    // bad range is judged on the right end before clamping
    if (lft > rgt) begin
      r.bad_range = 1'b1;
      return r;
    end
    if (rgt >= LEAVES) rgt = LEAVES - 1;
    if (lft <= rgt) r.range_sum = walk_sum(lft, rgt);
    return r;
  endfunction

  function automatic stprs_in_t set_word(int unsigned pos, logic [VAL_W-1:0] v);
    stprs_in_t w;
    w.kind      = KIND_SET;
    w.position  = pos[POS_W-1:0];
    w.right_end = POS_W'($urandom);
    w.value     = v;
    return w;
  endfunction

  function automatic stprs_in_t query_word(int unsigned lft, int unsigned rgt);
    stprs_in_t w;
    w.kind      = KIND_QUERY;
    w.position  = lft[POS_W-1:0];
    w.right_end = rgt[POS_W-1:0];
    w.value     = VAL_W'($urandom);
    return w;
  endfunction

  function automatic logic [VAL_W-1:0] draw_value();
    case ($urandom_range(0, 11))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return '0;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  task automatic send_word(input stprs_in_t w);
    int unsigned gap;
    gap = pause_for(src_paced);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (w.kind == KIND_QUERY) begin
      sums_due = {sums_due, predict_query(32'(w.position), 32'(w.right_end))};
    end else begin
      store_leaf(32'(w.position), w.value);
    end
  endtask

  // receiver: per word a random hold, plus a one-off long hold on request
  initial begin
    int unsigned hold;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      hold = pause_for(sink_paced) + sink_hold_extra;
      sink_hold_extra = 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (sums_due.size() == 0) begin
        $display("%0t: unexpected word sum=%0d bad=%0b", $time,
                 out_word.range_sum, out_word.bad_range);
        mismatches++;
      end else begin
        due = sums_due.pop_front();
        if (out_word.range_sum !== due.range_sum) begin
          $display("%0t: range_sum expected %0d got %0d", $time,
                   due.range_sum, out_word.range_sum);
          mismatches++;
        end
        if (out_word.bad_range !== due.bad_range) begin
          $display("%0t: bad_range expected %0b got %0b", $time,
                   due.bad_range, out_word.bad_range);
          mismatches++;
        end
      end
    end
  end

  task automatic test_empty_tree();
    send_word(query_word(0, TOP));
    send_word(query_word(0, 0));
    send_word(query_word(TOP, TOP));
    send_word(query_word(700, 699));
  endtask

  task automatic test_leaf_extremes();
    send_word(set_word(0, 32'h7FFF_FFFF));
    send_word(set_word(TOP, 32'h8000_0000));
    send_word(set_word(511, 32'hFFFF_FFFF));
    send_word(set_word(512, 32'h0000_0001));
    send_word(query_word(0, TOP));
    send_word(query_word(0, 0));
    send_word(query_word(TOP, TOP));
    send_word(query_word(511, 512));
    send_word(query_word(0, 511));
    send_word(query_word(512, TOP));
    send_word(query_word(TOP, 0));
  endtask

  task automatic test_overwrite();
    send_word(set_word(511, '0));
    send_word(set_word(0, 32'h8000_0000));
    send_word(query_word(0, TOP));
    send_word(query_word(0, 1));
  endtask

  // long receiver hold while queries keep coming: output register fills,
  // a finished query parks and the input side has to stall
  task automatic test_backpressure();
    int unsigned lft;
    src_paced = 1'b0;
    sink_hold_extra = 400;
    repeat (12) begin
      lft = $urandom_range(0, TOP);
      send_word(query_word(lft, $urandom_range(lft, TOP)));
    end
  endtask

  task automatic test_random_mix(int unsigned count);
    int unsigned n, pick, lft, rgt;
    for (n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        src_paced  = ($urandom_range(0, 3) != 0);
        sink_paced = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_word(set_word($urandom_range(0, TOP), draw_value()));
      end else if (pick < 53) begin
        lft = $urandom_range(1, TOP);
        send_word(query_word(lft, $urandom_range(0, lft - 1)));
      end else if (pick < 60) begin
        case ($urandom_range(0, 2))
          0:       send_word(query_word(0, TOP));
          1:       send_word(query_word(0, $urandom_range(0, TOP)));
          default: send_word(query_word($urandom_range(0, TOP), TOP));
        endcase
      end else if (pick < 75) begin
        lft = $urandom_range(0, TOP);
        rgt = lft + $urandom_range(0, 7);
        send_word(query_word(lft, (rgt > TOP) ? TOP : rgt));
      end else begin
        lft = $urandom_range(0, TOP);
        send_word(query_word(lft, $urandom_range(lft, TOP)));
      end
    end
  endtask

  task automatic finish_run();
    int unsigned waited;
    in_valid <= 1'b0;
    waited = 0;
    while (sums_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (sums_due.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, sums_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  endtask

  initial begin
    foreach (node_sum[k]) node_sum[k] = '0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_word  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_tree();
    test_leaf_extremes();
    test_overwrite();
    test_backpressure();
    test_random_mix(1550);
    finish_run();
  end

  initial begin
    #1_500_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ segment_tree_point_set_range_sum_unit.f @@
rtl/stprs_pkg.sv
rtl/stprs_node_ram.sv
rtl/segment_tree_point_set_range_sum_unit.sv
tb/tb.sv
